/* rtl/hkt_pkg.sv */
package hkt_pkg;

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001b3;

  localparam logic [1:0] KindGet = 2'd0;
  localparam logic [1:0] KindIns = 2'd1;
  localparam logic [1:0] KindDel = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        hit;
    logic        dropped;
  } result_t;

  // control part of the token that walks the cell chain
  typedef struct packed {
    logic       vld;
    logic       fill;   // 0: match pass, 1: free-slot fill pass
    logic [1:0] kind;
    logic       found;  // match seen (match pass) or slot taken (fill pass)
  } tok_ctl_t;

  // one FNV-1a byte step; the prime has few set bits, so this is a shift-add
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    logic [63:0] acc;
    x   = h ^ {56'd0, b};
    acc = '0;
    for (int i = 0; i < 64; i++) begin
      if (FnvPrime[i]) begin
        acc = acc + (x << i);
      end
    end
    return acc;
  endfunction

endpackage

/* rtl/hkt_cell.sv */
module hkt_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  hkt_pkg::tok_ctl_t     ctl_in,
  input  logic [63:0]           hash_in,
  input  logic [DATA_WIDTH-1:0] data_in,
  input  logic [DATA_WIDTH-1:0] rd_in,
  output hkt_pkg::tok_ctl_t     ctl_out,
  output logic [63:0]           hash_out,
  output logic [DATA_WIDTH-1:0] data_out,
  output logic [DATA_WIDTH-1:0] rd_out
);
  import hkt_pkg::*;

  logic                  valid;
  logic [63:0]           entry_hash;
  logic [DATA_WIDTH-1:0] entry_data;
  logic                  hit_here;
  logic                  take_here;
  tok_ctl_t              ctl_next;

  assign hit_here  = ctl_in.vld && !ctl_in.fill && !ctl_in.found && valid &&
                     (entry_hash == hash_in);
  assign take_here = ctl_in.vld && ctl_in.fill && !ctl_in.found && !valid;

  always_comb begin
    ctl_next       = ctl_in;
    ctl_next.found = ctl_in.found | hit_here | take_here;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_here) begin
      valid <= 1'b1;
    end else if (hit_here && ctl_in.kind == KindDel) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_here) begin
      entry_hash <= hash_in;
    end
    if (take_here || (hit_here && ctl_in.kind == KindIns)) begin
      entry_data <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    hash_out <= hash_in;
    data_out <= data_in;
    rd_out   <= (hit_here && ctl_in.kind == KindGet) ? entry_data : rd_in;
  end

endmodule

/* rtl/hash_keyed_table.sv */
// Keyed table addressed by a 64-bit FNV-1a hash of a streamed key. Each
// transfer (start high while busy is low) carries one key byte; a byte that
// is not the last folds into the running hash register and busy stays
// low. On the last byte the finished hash walks a chain of ENTRIES cells,
// one cell per cycle, each cell holding one entry and comparing it as the
// token passes. The result is registered from the tail of the chain and is
// taken at the edge that ends the cycle in which done is high; an insert
// that finds no match makes a second walk through the chain to claim the
// lowest free cell before its result is registered. busy is high from the
// last-byte transfer until the result is registered, so the next transfer
// can land at the edge that takes the result. Each result is shown for
// exactly one cycle with done high and the receiver cannot stall it. A get
// returns the stored value or zero, hit reports a matching entry, dropped
// flags an insert into a full table.
module hash_keyed_table #(
  parameter int ENTRIES    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hkt_pkg::cmd_t    cmd,
  output logic             done,
  output hkt_pkg::result_t result
);
  import hkt_pkg::*;

  // bits of the 32-bit value that survive into storage, and back out
  localparam int CW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FILL   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [63:0]           running_hash;
  logic [63:0]           hash_step;
  logic                  accept;
  logic                  launch;
  logic                  relaunch;
  logic                  emit;
  logic [DATA_WIDTH-1:0] data_new;

  // the chain: index 0 is the head input, index ENTRIES the tail output
  tok_ctl_t              ctl_c  [0:ENTRIES];
  logic [63:0]           hash_c [0:ENTRIES];
  logic [DATA_WIDTH-1:0] data_c [0:ENTRIES];
  logic [DATA_WIDTH-1:0] rd_c   [0:ENTRIES];
  logic [ENTRIES-1:0]    tok_vld;

  tok_ctl_t tail;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign launch    = accept && cmd.key_last;
  assign hash_step = fnv_step(running_hash, cmd.key_byte);
  assign data_new  = DATA_WIDTH'(cmd.value[CW-1:0]);
  assign tail      = ctl_c[ENTRIES];

  // insert that missed on the match walk goes round again to fill
  assign relaunch = tail.vld && !tail.fill && tail.kind == KindIns && !tail.found;
  assign emit     = tail.vld && !relaunch;

  // running hash: restarts at the basis once a key is complete
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FnvBasis;
    end else if (accept) begin
      running_hash <= cmd.key_last ? FnvBasis : hash_step;
    end
  end

  // chain head: a fresh key or the fill walk of a missed insert
  always_comb begin
    ctl_c[0]  = '0;
    hash_c[0] = hash_step;
    data_c[0] = data_new;
    rd_c[0]   = '0;
    if (relaunch) begin
      ctl_c[0].vld  = 1'b1;
      ctl_c[0].fill = 1'b1;
      ctl_c[0].kind = tail.kind;
      hash_c[0]     = hash_c[ENTRIES];
      data_c[0]     = data_c[ENTRIES];
    end else if (launch) begin
      ctl_c[0].vld  = 1'b1;
      ctl_c[0].kind = cmd.kind;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    hkt_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_c[i]),
      .hash_in (hash_c[i]),
      .data_in (data_c[i]),
      .rd_in   (rd_c[i]),
      .ctl_out (ctl_c[i+1]),
      .hash_out(hash_c[i+1]),
      .data_out(data_c[i+1]),
      .rd_out  (rd_c[i+1])
    );
    assign tok_vld[i] = ctl_c[i+1].vld;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (launch) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (relaunch) begin
          state_next = S_FILL;
        end else if (emit) begin
          state_next = S_IDLE;
        end
      end
      S_FILL: begin
        if (emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
    end
  end

  // result register; a fill walk reports a miss and whether a slot was found
  always_ff @(posedge clk) begin
    if (emit) begin
      if (tail.fill) begin
        result <= '{read_value: 32'd0, hit: 1'b0, dropped: ~tail.found};
      end else begin
        result <= '{read_value: 32'(rd_c[ENTRIES][CW-1:0]),
                    hit:        tail.found,
                    dropped:    1'b0};
      end
    end
  end

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vld))
    else $error("more than one token in the cell chain");
  a_tail_busy: assert property (@(posedge clk) disable iff (rst) tail.vld |-> busy)
    else $error("token left the chain while idle");
  a_done_work: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a key in flight");
  a_byte_fast: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && !cmd.key_last) |=> !busy)
    else $error("inner key byte held the block busy");
  a_fill_path: assert property (@(posedge clk) disable iff (rst)
      relaunch |-> (state == S_SEARCH))
    else $error("fill walk started outside the match walk");
`endif

endmodule
